>>> rtl/core/pdbs_pkg.sv
// Package for the pixel decimation and block swizzle block: widths, register
// indexes and the position record passed from the address generator.
// No dependencies.
package pdbs_pkg;

    // Largest supported input width in pixels; counter widths follow from it.
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int BAND_ROWS    = 16;
    localparam int BLOCK_COLS   = 8;
    localparam int BLOCK_PIXELS = 32;
    localparam int LINE_PIXELS  = 4;

    localparam int PIXEL_W = 32;
    localparam int OFF_W   = 18;
    localparam int CFG_W   = 11;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int WDIM_W = COL_W + 1;
    localparam int HDIM_W = ROW_W + 1;
    localparam int WCMP_W = (CFG_W > WDIM_W) ? CFG_W : WDIM_W;
    localparam int HCMP_W = (CFG_W > HDIM_W) ? CFG_W : HDIM_W;

    localparam int BAND_BITS  = $clog2(BAND_ROWS);
    localparam int BLOCK_BITS = $clog2(BLOCK_COLS);
    localparam int BPIX_BITS  = $clog2(BLOCK_PIXELS);
    localparam int LINE_BITS  = $clog2(LINE_PIXELS);
    localparam int STRIDE_W   = WDIM_W + BPIX_BITS - BLOCK_BITS + 1;

    // APB register map: register i at byte address 4*i.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_LSB = 2;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // Where the current item lands and whether it is kept.
    typedef struct packed {
        logic             keep;
        logic [OFF_W-1:0] dest_offset;
        logic             image_done;
    } pos_t;

endpackage

>>> rtl/core/pdbs_if.sv
// Valid/ready channel interfaces for the pixel input and the placed output.
// Depends on pdbs_pkg.
interface pdbs_in_if;
    logic                         valid;
    logic                         ready;
    logic [pdbs_pkg::PIXEL_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface pdbs_out_if;
    logic                         valid;
    logic                         ready;
    logic [pdbs_pkg::PIXEL_W-1:0] out_pixel;
    logic [pdbs_pkg::OFF_W-1:0]   dest_offset;
    logic                         image_done;

    modport source (output valid, output out_pixel, output dest_offset, output image_done,
                    input ready);
    modport sink   (input valid, input out_pixel, input dest_offset, input image_done,
                    output ready);
endinterface

>>> rtl/core/pdbs_addr_gen.sv
// Raster position counters and swizzled destination offset generator.
// Depends on pdbs_pkg.
module pdbs_addr_gen (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [pdbs_pkg::WDIM_W-1:0]   eff_width,
    input  logic [pdbs_pkg::HDIM_W-1:0]   eff_height,
    input  logic [pdbs_pkg::STRIDE_W-1:0] band_stride,
    output pdbs_pkg::pos_t                pos
);
    import pdbs_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [OFF_W-1:0] base_reg, base_next;

    logic [WDIM_W-1:0] col_inc;
    logic [HDIM_W-1:0] row_inc;
    logic              row_end;
    logic              image_end;
    logic [WDIM_W-1:0] last_even_col;
    logic [HDIM_W-1:0] last_even_row;

    assign col_inc   = WDIM_W'(col_reg) + WDIM_W'(1);
    assign row_inc   = HDIM_W'(row_reg) + HDIM_W'(1);
    assign row_end   = (col_inc >= eff_width);
    assign image_end = (row_inc >= eff_height);

    assign last_even_col = (eff_width - WDIM_W'(1)) & ~WDIM_W'(1);
    assign last_even_row = (eff_height - HDIM_W'(1)) & ~HDIM_W'(1);

    always_comb
    begin
        pos.keep        = ~col_reg[0] & ~row_reg[0];
        pos.dest_offset = base_reg
                        + OFF_W'({col_reg[COL_W-1:BLOCK_BITS], {BPIX_BITS{1'b0}}})
                        + OFF_W'({row_reg[BAND_BITS-1:1], {LINE_BITS{1'b0}}})
                        + OFF_W'(col_reg[BLOCK_BITS-1:1]);
        pos.image_done  = (WDIM_W'(col_reg) == last_even_col)
                        && (HDIM_W'(row_reg) == last_even_row);
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (!row_end) begin
            col_next = col_inc[COL_W-1:0];
        end else begin
            col_next = '0;
            if (image_end) begin
                row_next  = '0;
                base_next = '0;
            end else begin
                row_next = row_inc[ROW_W-1:0];
                // Leaving the last row of a band moves the base on by one stride.
                if (row_reg[BAND_BITS-1:0] == {BAND_BITS{1'b1}}) begin
                    base_next = base_reg + OFF_W'(band_stride);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else if (advance) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

>>> rtl/core/pixel_decimate_block_swizzle.sv
// Top level of the pixel decimation and block swizzle block: APB register
// file, input handshake and result register. Depends on pdbs_pkg, pdbs_if
// and pdbs_addr_gen.
//
// The block takes decoded 32-bit RGBA pixels of one image in raster order and
// keeps only those at an even column of an even row, halving the image in
// both directions. Each kept pixel leaves with its destination pixel index in
// a block-swizzled layout: bands of 16 input rows, blocks of 8 input columns
// that become 4 output pixels by 8 output lines, and a band stride of
// ceil(width/8)*32 pixels; image_done marks the last kept pixel, after which
// the counters return to zero for the next image. Offsets wrap modulo 2^18.
// The position counters and the offset adders keep up with one item per clock
// while the output channel does not stall, and the result register sits
// between the two channels so that a new item is taken in the same cycle as
// the waiting result leaves. Odd-position items give no result. The width
// (register 0, byte address 0) and height (register 1, byte address 4) are
// 11-bit registers; zero is treated as 1 and values above 1024 as 1024. They
// should be written only while the block is idle; a change mid-image takes
// effect at once and does not clear the counters.
module pixel_decimate_block_swizzle (
    input  logic                         clk,
    input  logic                         rst_n,
    pdbs_in_if.sink                      in_ch,
    pdbs_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdbs_pkg::PADDR_W-1:0] paddr,
    input  logic [pdbs_pkg::PDATA_W-1:0] pwdata,
    output logic [pdbs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import pdbs_pkg::*;

    // Configuration registers, reset to a 1 by 1 image.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    reg_index_t reg_sel;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[REG_LSB]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end else if (cfg_write) begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective image size: zero reads as one, large values are clamped.
    logic [WCMP_W-1:0]   width_ext;
    logic [HCMP_W-1:0]   height_ext;
    logic [WDIM_W-1:0]   eff_width;
    logic [HDIM_W-1:0]   eff_height;
    logic [WDIM_W:0]     width_round;
    logic [STRIDE_W-1:0] band_stride;

    assign width_ext  = WCMP_W'(width_reg);
    assign height_ext = HCMP_W'(height_reg);

    always_comb
    begin
        if (width_ext == '0) begin
            eff_width = WDIM_W'(1);
        end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
            eff_width = WDIM_W'(MAX_WIDTH);
        end else begin
            eff_width = width_ext[WDIM_W-1:0];
        end

        if (height_ext == '0) begin
            eff_height = HDIM_W'(1);
        end else if (height_ext > HCMP_W'(HEIGHT_LIMIT)) begin
            eff_height = HDIM_W'(HEIGHT_LIMIT);
        end else begin
            eff_height = height_ext[HDIM_W-1:0];
        end
    end

    // Band stride is the number of blocks across, times the pixels of a block.
    assign width_round = (WDIM_W + 1)'(eff_width) + (WDIM_W + 1)'(BLOCK_COLS - 1);
    assign band_stride = STRIDE_W'({width_round[WDIM_W:BLOCK_BITS], {BPIX_BITS{1'b0}}});

    // Input handshake: an item is taken whenever the result register is
    // empty or its content leaves in this same cycle.
    logic  in_accept;
    pos_t  pos;

    assign in_ch.ready = !out_ch.valid || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    pdbs_addr_gen u_addr_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_accept),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .band_stride (band_stride),
        .pos         (pos)
    );

    // Result register.
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic [OFF_W-1:0]   dest_offset_reg;
    logic               image_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= pos.keep;
        end else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && pos.keep) begin
            out_pixel_reg   <= in_ch.pixel_value;
            dest_offset_reg <= pos.dest_offset;
            image_done_reg  <= pos.image_done;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_pixel   = out_pixel_reg;
    assign out_ch.dest_offset = dest_offset_reg;
    assign out_ch.image_done  = image_done_reg;

endmodule
